// ----- rtl/core/ecu_pkg.sv -----
// ----------------------------------------------------------------------------
// ecu_pkg: shared types and constants of the easing curve unit
// Curve codes, per-word tags and the elaboration-time tables for the
// exponential and sine kernels.
// ----------------------------------------------------------------------------
package ecu_pkg;

  // Kernel that produces the in-curve value of a word
  typedef enum logic [2:0] {
    K_QUAD,
    K_CUBIC,
    K_QUART,
    K_QUINT,
    K_EXPO,
    K_CIRC,
    K_SINE,
    K_LINEAR
  } kind_e;

  // Operation applied to the kernel value on the way out
  typedef enum logic [1:0] {
    P_PLAIN,
    P_OUT,
    P_IO_LO,
    P_IO_HI
  } post_e;

  typedef struct packed {
    kind_e kind;
    post_e post;
  } tag_t;

  localparam int unsigned TagW = $bits(tag_t);

  // Curve register codes
  localparam logic [4:0] CURVE_IN_FIRST  = 5'd1;
  localparam logic [4:0] CURVE_IN_LAST   = 5'd7;
  localparam logic [4:0] CURVE_OUT_FIRST = 5'd8;
  localparam logic [4:0] CURVE_OUT_LAST  = 5'd14;
  localparam logic [4:0] CURVE_IO_FIRST  = 5'd15;
  localparam logic [4:0] CURVE_IO_LAST   = 5'd21;

  // Q1.30 working format
  localparam int unsigned QW    = 31;
  localparam logic [QW-1:0] Q30 = 31'h4000_0000;
  localparam logic [61:0] RND30 = 62'h0000_0000_2000_0000;
  localparam logic [63:0] Q30W  = 64'h0000_0000_4000_0000;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] v;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    v = x;
    for (int n = 0; n < 32; n++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Restoring long division, used only on constants
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[62:0], num[k]};
      if (rem >= den) begin
        rem  = rem - den;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // 2^(-2^-i) in Q1.30
  function automatic logic [QW-1:0] exp_root(input int unsigned i);
    logic [63:0] r;
    r = 64'h0000_0000_2000_0000;
    for (int unsigned k = 1; k <= i; k++) begin
      r = isqrt64(r << 30);
    end
    return r[QW-1:0];
  endfunction

  // Cosine or sine of pi/2 * 2^-i in Q1.30, half-angle recurrence
  function automatic logic [QW-1:0] rot_const(input int unsigned i, input logic want_sin);
    logic [63:0] c;
    logic [63:0] s;
    logic [63:0] cn;
    c = '0;
    s = Q30W;
    for (int unsigned k = 1; k <= i; k++) begin
      cn = isqrt64(((Q30W + c) >> 1) << 30);
      s  = udiv64((s << 30) + cn, cn << 1);
      c  = cn;
    end
    return want_sin ? s[QW-1:0] : c[QW-1:0];
  endfunction

endpackage

// ----- rtl/core/ecu_front.sv -----
// ----------------------------------------------------------------------------
// ecu_front: input stage of the easing curve unit
// Holds the curve register, saturates progress and maps each word to a
// kernel argument and an output operation.
// ----------------------------------------------------------------------------
module ecu_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [FRAC_BITS:0]   in_progress_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [4:0]           cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ecu_pkg::tag_t        out_tag_o,
  output logic [FRAC_BITS:0]   out_u_o
);

  localparam int unsigned F = FRAC_BITS;
  localparam logic [F:0] One = {1'b1, {F{1'b0}}};

  logic [4:0]      curve_q;
  logic            fv_q;
  ecu_pkg::tag_t   tag_q, tag_d;
  logic [F:0]      u_q, u_d;
  logic [F:0]      t_sat;
  logic [F+1:0]    dbl;
  logic [F+1:0]    rev;
  logic            accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = !fv_q || out_ready_i;

  always_comb begin
    t_sat = (in_progress_i > One) ? One : in_progress_i;
    dbl   = {t_sat, 1'b0};
    rev   = {One, 1'b0} - dbl;
    tag_d.kind = ecu_pkg::K_LINEAR;
    tag_d.post = ecu_pkg::P_PLAIN;
    u_d        = t_sat;
    case (curve_q) inside
      [ecu_pkg::CURVE_IN_FIRST:ecu_pkg::CURVE_IN_LAST]: begin
        tag_d.kind = ecu_pkg::kind_e'(3'(curve_q - ecu_pkg::CURVE_IN_FIRST));
      end
      [ecu_pkg::CURVE_OUT_FIRST:ecu_pkg::CURVE_OUT_LAST]: begin
        tag_d.kind = ecu_pkg::kind_e'(3'(curve_q - ecu_pkg::CURVE_OUT_FIRST));
        tag_d.post = ecu_pkg::P_OUT;
        u_d        = One - t_sat;
      end
      [ecu_pkg::CURVE_IO_FIRST:ecu_pkg::CURVE_IO_LAST]: begin
        tag_d.kind = ecu_pkg::kind_e'(3'(curve_q - ecu_pkg::CURVE_IO_FIRST));
        if (dbl < {1'b0, One}) begin
          tag_d.post = ecu_pkg::P_IO_LO;
          u_d        = dbl[F:0];
        end else begin
          tag_d.post = ecu_pkg::P_IO_HI;
          u_d        = rev[F:0];
        end
      end
      default: begin
        tag_d.kind = ecu_pkg::K_LINEAR;
        tag_d.post = ecu_pkg::P_PLAIN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_q <= '0;
      fv_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        curve_q <= cfg_data_i;
      end
      if (accept) begin
        fv_q <= 1'b1;
      end else if (out_ready_i) begin
        fv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag_q <= tag_d;
      u_q   <= u_d;
    end
  end

  assign out_valid_o = fv_q;
  assign out_tag_o   = tag_q;
  assign out_u_o     = u_q;

endmodule

// ----- rtl/core/ecu_fifo.sv -----
// ----------------------------------------------------------------------------
// ecu_fifo: small word queue between front and back
// Flop-based first-in first-out buffer with a fill count.
// ----------------------------------------------------------------------------
module ecu_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign in_ready_o  = cnt_q != CntW'(DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

endmodule

// ----- rtl/core/ecu_back.sv -----
// ----------------------------------------------------------------------------
// ecu_back: kernel pipeline of the easing curve unit
// Power, exponential, circular and sine kernels run side by side on one
// stall-together pipeline; each drops its value into the result lane at
// its last stage, then the output stage applies the curve form.
// ----------------------------------------------------------------------------
module ecu_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ecu_pkg::tag_t      in_tag_i,
  input  logic [FRAC_BITS:0] in_u_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [FRAC_BITS:0] out_eased_o
);

  localparam int unsigned F       = FRAC_BITS;
  localparam int unsigned QW      = ecu_pkg::QW;
  localparam int unsigned Lat     = 2 * F + 3;
  localparam int unsigned PowEnd  = 4;
  localparam int unsigned ExpEnd  = F + 2;
  localparam int unsigned CircEnd = F + 3;
  localparam int unsigned RadW    = 2 * F + 2;
  localparam int unsigned RemW    = F + 4;
  localparam int unsigned ShQ     = 30 - F;
  localparam logic [F:0] One      = {1'b1, {F{1'b0}}};
  localparam logic [F:0] Half     = {2'b01, {(F-1){1'b0}}};
  localparam logic [2*F+1:0] MulRnd = {{(F+2){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic [31:0] CosRnd  = 32'd1 << (ShQ - 1);

  function automatic logic [F:0] fx_mul(input logic [F:0] a, input logic [F:0] b);
    logic [2*F+1:0] p;
    p = {{(F+1){1'b0}}, a} * {{(F+1){1'b0}}, b} + MulRnd;
    return p[2*F:F];
  endfunction

  logic                adv;
  logic [Lat:0]        vld_q;
  ecu_pkg::tag_t       tag_q [Lat+1];
  logic [F:0]          u_q   [Lat+1];
  logic [F:0]          res_q [Lat+1];
  logic [F:0]          pow_fin, exp_fin, circ_fin, sin_fin;
  logic                out_valid_q;
  logic [F:0]          out_q;

  logic [F:0]          pw_q   [1:PowEnd-1];
  logic [3:0]          ek_q   [1:ExpEnd-1];
  logic [F-1:0]        ef_q   [1:ExpEnd-1];
  logic [QW-1:0]       acc_q  [1:ExpEnd-1];
  logic [RadW-1:0]     rad_q  [1:CircEnd-1];
  logic [RemW-1:0]     rem_q  [1:CircEnd-1];
  logic [F:0]          root_q [1:CircEnd-1];
  logic [F:0]          sa_flag_q;
  logic [61:0]         sa_cc_q [F+1];
  logic [61:0]         sa_ss_q [F+1];
  logic [61:0]         sa_sc_q [F+1];
  logic [61:0]         sa_cs_q [F+1];
  logic [QW-1:0]       sa_cx_q [F+1];
  logic [QW-1:0]       sa_sy_q [F+1];
  logic [QW-1:0]       sb_cx_q [F+1];
  logic [QW-1:0]       sb_sy_q [F+1];

  // the whole pipe moves while the output slot is free or being taken
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[Lat-1:0], in_valid_i};
      out_valid_q <= vld_q[Lat];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag_q[0] <= in_tag_i;
      u_q[0]   <= in_u_i;
      res_q[0] <= in_u_i;
    end
  end

  // result lane: linear passes through, each kernel overwrites at its end
  for (genvar j = 1; j <= Lat; j++) begin : g_lane
    logic [F:0] res_nxt;
    if (j == PowEnd) begin : g_pow
      assign res_nxt = (tag_q[j-1].kind <= ecu_pkg::K_QUINT) ? pow_fin : res_q[j-1];
    end else if (j == ExpEnd) begin : g_exp
      assign res_nxt = (tag_q[j-1].kind == ecu_pkg::K_EXPO) ? exp_fin : res_q[j-1];
    end else if (j == CircEnd) begin : g_circ
      assign res_nxt = (tag_q[j-1].kind == ecu_pkg::K_CIRC) ? circ_fin : res_q[j-1];
    end else if (j == Lat) begin : g_sin
      assign res_nxt = (tag_q[j-1].kind == ecu_pkg::K_SINE) ? sin_fin : res_q[j-1];
    end else begin : g_copy
      assign res_nxt = res_q[j-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        tag_q[j] <= tag_q[j-1];
        u_q[j]   <= u_q[j-1];
        res_q[j] <= res_nxt;
      end
    end
  end

  // powers: one rounded product per stage, as many as the kind needs
  for (genvar j = 1; j <= PowEnd; j++) begin : g_power
    logic [F:0] pw_in, pw_val;
    if (j == 1) begin : g_first
      assign pw_in = u_q[0];
    end else begin : g_next
      assign pw_in = pw_q[j-1];
    end
    assign pw_val = (3'(j - 1) <= tag_q[j-1].kind) ? fx_mul(pw_in, u_q[j-1]) : pw_in;
    if (j == PowEnd) begin : g_end
      assign pow_fin = pw_val;
    end else begin : g_reg
      always_ff @(posedge clk_i) begin
        if (adv) begin
          pw_q[j] <= pw_val;
        end
      end
    end
  end

  // exponential: split 10*(1-u), multiply in one root per fraction bit
  for (genvar j = 1; j <= ExpEnd; j++) begin : g_expo
    if (j == 1) begin : g_split
      logic [F:0]   ex_x;
      logic [F+3:0] ex_e;
      assign ex_x = One - u_q[0];
      assign ex_e = {ex_x, 3'b000} + {2'b00, ex_x, 1'b0};
      always_ff @(posedge clk_i) begin
        if (adv) begin
          ek_q[j]  <= ex_e[F+3:F];
          ef_q[j]  <= ex_e[F-1:0];
          acc_q[j] <= ecu_pkg::Q30;
        end
      end
    end else if (j < ExpEnd) begin : g_root
      localparam logic [QW-1:0] Root = ecu_pkg::exp_root(j - 1);
      logic [61:0] ex_p;
      assign ex_p = {31'b0, acc_q[j-1]} * {31'b0, Root} + ecu_pkg::RND30;
      always_ff @(posedge clk_i) begin
        if (adv) begin
          ek_q[j]  <= ek_q[j-1];
          ef_q[j]  <= ef_q[j-1];
          acc_q[j] <= ef_q[j-1][F-j+1] ? ex_p[60:30] : acc_q[j-1];
        end
      end
    end else begin : g_scale
      logic [5:0]  ex_s;
      logic [33:0] ex_sum, ex_sh;
      assign ex_s    = 6'(ShQ) + {2'b00, ek_q[j-1]};
      assign ex_sum  = {3'b000, acc_q[j-1]} + (34'd1 << (ex_s - 6'd1));
      assign ex_sh   = ex_sum >> ex_s;
      assign exp_fin = ex_sh[F:0];
    end
  end

  // circular: 1 - u^2, then one root digit per stage
  for (genvar j = 1; j <= CircEnd; j++) begin : g_circ
    if (j == 1) begin : g_sq
      logic [F:0] ci_d;
      assign ci_d = One - fx_mul(u_q[0], u_q[0]);
      always_ff @(posedge clk_i) begin
        if (adv) begin
          rad_q[j]  <= {1'b0, ci_d, {F{1'b0}}};
          rem_q[j]  <= '0;
          root_q[j] <= '0;
        end
      end
    end else if (j < CircEnd) begin : g_digit
      localparam int unsigned Dig = F + 2 - j;
      logic [RemW-1:0] ci_rem, ci_trial;
      assign ci_rem   = {rem_q[j-1][RemW-3:0], rad_q[j-1][2*Dig+1:2*Dig]};
      assign ci_trial = {1'b0, root_q[j-1], 2'b01};
      always_ff @(posedge clk_i) begin
        if (adv) begin
          rad_q[j] <= rad_q[j-1];
          if (ci_rem >= ci_trial) begin
            rem_q[j]  <= ci_rem - ci_trial;
            root_q[j] <= {root_q[j-1][F-1:0], 1'b1};
          end else begin
            rem_q[j]  <= ci_rem;
            root_q[j] <= {root_q[j-1][F-1:0], 1'b0};
          end
        end
      end
    end else begin : g_fin
      logic [F:0] ci_r;
      assign ci_r     = (root_q[j-1] > One) ? One : root_q[j-1];
      assign circ_fin = One - ci_r;
    end
  end

  // sine: products of one rotation, then their combination
  for (genvar i = 0; i <= F; i++) begin : g_rot
    localparam logic [QW-1:0] Cc = ecu_pkg::rot_const(i, 1'b0);
    localparam logic [QW-1:0] Ss = ecu_pkg::rot_const(i, 1'b1);
    logic [QW-1:0] cx_in, sy_in;
    logic [61:0]   rt_dif, rt_sum;
    logic [31:0]   rt_nc, rt_ns;
    if (i == 0) begin : g_init
      assign cx_in = ecu_pkg::Q30;
      assign sy_in = '0;
    end else begin : g_prev
      assign cx_in = sb_cx_q[i-1];
      assign sy_in = sb_sy_q[i-1];
    end
    assign rt_dif = sa_cc_q[i] - sa_ss_q[i] + ecu_pkg::RND30;
    assign rt_sum = sa_sc_q[i] + sa_cs_q[i] + ecu_pkg::RND30;
    assign rt_nc  = (sa_cc_q[i] >= sa_ss_q[i]) ? rt_dif[61:30] : '0;
    assign rt_ns  = rt_sum[61:30];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sa_flag_q[i] <= u_q[2*i][F-i];
        sa_cc_q[i]   <= {31'b0, cx_in} * {31'b0, Cc};
        sa_ss_q[i]   <= {31'b0, sy_in} * {31'b0, Ss};
        sa_sc_q[i]   <= {31'b0, sy_in} * {31'b0, Cc};
        sa_cs_q[i]   <= {31'b0, cx_in} * {31'b0, Ss};
        sa_cx_q[i]   <= cx_in;
        sa_sy_q[i]   <= sy_in;
        if (sa_flag_q[i]) begin
          sb_cx_q[i] <= (rt_nc > {1'b0, ecu_pkg::Q30}) ? ecu_pkg::Q30 : rt_nc[QW-1:0];
          sb_sy_q[i] <= (rt_ns > {1'b0, ecu_pkg::Q30}) ? ecu_pkg::Q30 : rt_ns[QW-1:0];
        end else begin
          sb_cx_q[i] <= sa_cx_q[i];
          sb_sy_q[i] <= sa_sy_q[i];
        end
      end
    end
  end

  logic [31:0] cs_sum, cs_sh;
  logic [F:0]  cs_f;
  assign cs_sum  = {1'b0, sb_cx_q[F]} + CosRnd;
  assign cs_sh   = cs_sum >> ShQ;
  assign cs_f    = (cs_sh[F:0] > One) ? One : cs_sh[F:0];
  assign sin_fin = One - cs_f;

  // output form
  logic [F:0]   po_y, po_inv, po_v;
  logic [F+1:0] po_ysum, po_isum;

  always_comb begin
    po_y    = res_q[Lat];
    po_inv  = One - po_y;
    po_ysum = {1'b0, po_y} + 1'b1;
    po_isum = {1'b0, po_inv} + 1'b1;
    case (tag_q[Lat].post)
      ecu_pkg::P_PLAIN: po_v = po_y;
      ecu_pkg::P_OUT:   po_v = po_inv;
      ecu_pkg::P_IO_LO: po_v = po_ysum[F+1:1];
      ecu_pkg::P_IO_HI: po_v = Half + po_isum[F+1:1];
      default:          po_v = po_y;
    endcase
    if (po_v > One) begin
      po_v = One;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= po_v;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_eased_o = out_q;

endmodule

// ----- rtl/core/easing_curve_unit_core.sv -----
// ----------------------------------------------------------------------------
// easing_curve_unit_core: Penner easing curves in unsigned fixed point
// Maps a progress word to its eased value for the curve held in the
// configuration register.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                   payload
//   s_axis    in         s_axis_tvalid/tready        tdata: progress
//   m_axis    out        m_axis_tvalid/tready        tdata: eased
//   cfg       in         cfg_valid/ready             data: curve code
//
// One word is accepted per cycle while the queue has room. A word passes
// the front register, the queue and the kernel pipe on its way to m_axis;
// the sine kernel, with two stages per half-angle rotation, sets the pipe depth.
// Reset clears the curve register to linear and empties every stage.
// A stalled m_axis freezes the kernel pipe; the queue behind the front
// keeps s_axis taking words until it fills.
module easing_curve_unit_core #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned QUEUE_DEPTH = 4,
  localparam int unsigned TdataW     = ((FRAC_BITS + 8) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [TdataW-1:0] s_axis_tdata_i,   // [FRAC_BITS:0] progress, rest zero
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [TdataW-1:0] m_axis_tdata_o,   // [FRAC_BITS:0] eased, rest zero
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [4:0]        cfg_data_i
);

  localparam int unsigned QueueW = ecu_pkg::TagW + FRAC_BITS + 1;

  // front to queue
  logic               fr_valid, fr_ready;
  ecu_pkg::tag_t      fr_tag;
  logic [FRAC_BITS:0] fr_u;

  // queue to back
  logic               bk_valid, bk_ready;
  logic [QueueW-1:0]  bk_word;
  ecu_pkg::tag_t      bk_tag;
  logic [FRAC_BITS:0] bk_u;
  logic [FRAC_BITS:0] eased;

  // saturate, decode the curve, build the kernel argument
  ecu_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_progress_i (s_axis_tdata_i[FRAC_BITS:0]),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (fr_valid),
    .out_ready_i   (fr_ready),
    .out_tag_o     (fr_tag),
    .out_u_o       (fr_u)
  );

  // hold decoded words while the kernel pipe is stalled
  ecu_fifo #(
    .WIDTH (QueueW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_data_i   ({fr_u, fr_tag}),
    .out_valid_o (bk_valid),
    .out_ready_i (bk_ready),
    .out_data_o  (bk_word)
  );

  assign bk_tag = ecu_pkg::tag_t'(bk_word[ecu_pkg::TagW-1:0]);
  assign bk_u   = bk_word[QueueW-1:ecu_pkg::TagW];

  // kernels and the output register
  ecu_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bk_valid),
    .in_ready_o  (bk_ready),
    .in_tag_i    (bk_tag),
    .in_u_i      (bk_u),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_eased_o (eased)
  );

  // zero-pad to whole bytes
  assign m_axis_tdata_o = TdataW'(eased);

endmodule
